### design/rolling_hash_substring_search_defines.svh
// Assertion macros shared by the substring search RTL.
`ifndef ROLLING_HASH_SUBSTRING_SEARCH_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every clock once reset is released.
`define RHSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock once reset is released.
`define RHSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/rhss_pkg.sv
// Types and constants for the rolling hash substring search.
package rhss_pkg;

    localparam int HASH_W = 30;
    localparam int PROD_W = 38;
    localparam int QUO_W  = 9;
    localparam int REM_W  = 32;

    localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000007;
    localparam logic [REM_W-1:0]  HASH_MOD2   = 32'd2000000014;
    localparam logic [7:0]        HASH_BASE   = 8'd100;
    // floor(2^38 / HASH_MOD), applied to bits [37:29] of the product
    localparam logic [QUO_W-1:0]  HASH_RECIP  = 9'd274;
    localparam int                RECIP_SHIFT = 9;

    localparam int MAX_PATTERN_DEF = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_QEST,
        S_REM,
        S_FIX,
        S_DIFF,
        S_CMP_RD,
        S_CMP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        J_PHASH,
        J_TPOW,
        J_ROLLSUB,
        J_WFOLD
    } t_job;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

endpackage

### design/rolling_hash_substring_search.sv
// Rabin-Karp substring search: pattern bytes (i_action = 0) are stored and hashed as
// h*100+c mod 1000000007; text bytes (i_action = 1) roll a window hash over a ring of
// pattern-length entries, and each hash hit is confirmed byte by byte against the stored
// pattern. The last text byte yields one beat with o_found and o_status (0 ok, 1 text
// shorter than pattern, 2 pattern over MAX_PATTERN) and returns the block to its reset
// state. Pace is set by one shared modular reduction unit (multiply, quotient estimate,
// subtract, correct), and o_stall holds off the next byte until the last is through: a
// pattern byte takes one reduction (a second from the second byte on, which also
// advances the top power), a text byte one while the window fills and a second, for the
// dropped byte, once it slides; a hash hit adds a compare walk over the two memories (it
// stops at the first differing byte), and the last text byte then posts its result,
// waiting while the previous result is still held by the receiver. Bytes arriving after
// an overflow or before any pattern byte skip the unit. No clearing pass after reset.
`include "rolling_hash_substring_search_defines.svh"

module rolling_hash_substring_search #(
    parameter int MAX_PATTERN = rhss_pkg::MAX_PATTERN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_char_value,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_found,
    output logic [1:0] o_status
);
    import rhss_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // pattern store and window ring
    logic [7:0] pstore [MAX_PATTERN];
    logic [7:0] ring   [MAX_PATTERN];

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_rp, n_rp;
    logic [HASH_W-1:0] r_ph, n_ph;
    logic [HASH_W-1:0] r_wh, n_wh;
    logic [HASH_W-1:0] r_tp, n_tp;
    logic              r_found, n_found;
    logic              r_ovf, n_ovf;
    logic              r_closed, n_closed;
    logic              r_tp_pend, n_tp_pend;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;

    logic [7:0]        r_c, n_c;
    logic [PROD_W-1:0] r_x, n_x;
    logic [QUO_W-1:0]  r_q, n_q;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [HASH_W-1:0] r_sub, n_sub;
    logic [HASH_W-1:0] r_opa, n_opa;
    logic [AW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_vp, n_vp;
    logic              r_out_found, n_out_found;
    t_status           r_out_status, n_out_status;
    logic [7:0]        r_rq;
    logic [7:0]        r_pq;

    logic              accept;
    logic              emit_go;
    logic              pstore_we;
    logic              ring_we;
    logic              ring_re;
    logic [AW-1:0]     ring_ra;
    logic [HASH_W-1:0] mul_a;
    logic [7:0]        mul_b;
    logic [7:0]        mul_c;
    logic [REM_W-1:0]  rem_m1;
    logic [REM_W-1:0]  rem_m2;
    logic [HASH_W-1:0] fix_res;
    logic [HASH_W:0]   diff_hi;
    logic [HASH_W-1:0] diff_res;
    logic [PROD_W:0]   qm;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p,
                                                input logic [LW-1:0] len);
        logic [LW:0] inc;
        inc = (LW+1)'(p) + 1'b1;
        return (inc >= (LW+1)'(len)) ? '0 : inc[AW-1:0];
    endfunction

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign emit_go  = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_found  = r_out_found;
    assign o_status = r_out_status;

    // operand select for the shared multiply
    always_comb begin
        unique case (r_job)
            J_PHASH: begin
                mul_a = r_ph;
                mul_b = HASH_BASE;
                mul_c = r_c;
            end
            J_TPOW: begin
                mul_a = r_tp;
                mul_b = HASH_BASE;
                mul_c = '0;
            end
            J_ROLLSUB: begin
                mul_a = r_tp;
                mul_b = r_rq;
                mul_c = '0;
            end
            J_WFOLD: begin
                mul_a = r_opa;
                mul_b = HASH_BASE;
                mul_c = r_c;
            end
            default: begin
                mul_a = r_opa;
                mul_b = HASH_BASE;
                mul_c = r_c;
            end
        endcase
    end

    // final correction: the quotient estimate runs at most two low
    assign rem_m1  = r_rem - REM_W'(HASH_MOD);
    assign rem_m2  = r_rem - HASH_MOD2;
    assign fix_res = (r_rem >= HASH_MOD2)       ? rem_m2[HASH_W-1:0] :
                     (r_rem >= REM_W'(HASH_MOD)) ? rem_m1[HASH_W-1:0] :
                                                   r_rem[HASH_W-1:0];

    assign qm       = (PROD_W+1)'(r_q) * (PROD_W+1)'(HASH_MOD);
    assign diff_hi  = (HASH_W+1)'(r_wh) + (HASH_W+1)'(HASH_MOD) - (HASH_W+1)'(r_sub);
    assign diff_res = (r_wh >= r_sub) ? (r_wh - r_sub) : diff_hi[HASH_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_rp         = r_rp;
        n_ph         = r_ph;
        n_wh         = r_wh;
        n_tp         = r_tp;
        n_found      = r_found;
        n_ovf        = r_ovf;
        n_closed     = r_closed;
        n_tp_pend    = r_tp_pend;
        n_last       = r_last;
        n_c          = r_c;
        n_x          = r_x;
        n_q          = r_q;
        n_rem        = r_rem;
        n_sub        = r_sub;
        n_opa        = r_opa;
        n_j          = r_j;
        n_vp         = r_vp;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_valid  = (r_out_valid && !i_stall) ? 1'b0 : r_out_valid;
        pstore_we    = 1'b0;
        ring_we      = 1'b0;
        ring_re      = 1'b0;
        ring_ra      = r_vp;

        unique case (r_state)
            S_IDLE: begin
                ring_ra = r_rp;
                if (accept) begin
                    n_c    = i_char_value;
                    n_last = i_last;
                    if (!i_action) begin
                        if (!r_closed) begin
                            n_closed = i_last;
                            if (r_len == LW'(MAX_PATTERN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                pstore_we = 1'b1;
                                n_len     = r_len + 1'b1;
                                n_tp_pend = (r_len != '0);
                                n_job     = J_PHASH;
                                n_state   = S_MUL;
                            end
                        end
                    end else begin
                        n_closed = 1'b1;
                        if (r_ovf || r_len == '0) begin
                            if (!r_ovf) begin
                                n_found = 1'b1;
                            end
                            n_state = i_last ? S_EMIT : S_IDLE;
                        end else begin
                            // read the oldest byte, then overwrite it
                            ring_re = 1'b1;
                            ring_we = 1'b1;
                            n_rp    = next_slot(r_rp, r_len);
                            n_state = S_MUL;
                            if (r_cnt == r_len) begin
                                n_job = J_ROLLSUB;
                            end else begin
                                n_cnt = r_cnt + 1'b1;
                                n_opa = r_wh;
                                n_job = J_WFOLD;
                            end
                        end
                    end
                end
            end
            S_MUL: begin
                n_x     = PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(mul_c);
                n_state = S_QEST;
            end
            S_QEST: begin
                n_q = QUO_W'(((2*QUO_W)'(r_x[PROD_W-1:PROD_W-QUO_W]) *
                              (2*QUO_W)'(HASH_RECIP)) >> RECIP_SHIFT);
                n_state = S_REM;
            end
            S_REM: begin
                n_rem   = REM_W'((PROD_W+1)'(r_x) - qm);
                n_state = S_FIX;
            end
            S_FIX: begin
                unique case (r_job)
                    J_PHASH: begin
                        n_ph = fix_res;
                        if (r_tp_pend) begin
                            n_job   = J_TPOW;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    J_TPOW: begin
                        n_tp    = fix_res;
                        n_state = S_IDLE;
                    end
                    J_ROLLSUB: begin
                        n_sub   = fix_res;
                        n_state = S_DIFF;
                    end
                    J_WFOLD: begin
                        n_wh = fix_res;
                        if (r_cnt == r_len && fix_res == r_ph) begin
                            n_j     = '0;
                            n_vp    = r_rp;
                            n_state = S_CMP_RD;
                        end else begin
                            n_state = r_last ? S_EMIT : S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIFF: begin
                n_opa   = diff_res;
                n_job   = J_WFOLD;
                n_state = S_MUL;
            end
            S_CMP_RD: begin
                ring_re = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                // walk the window oldest first against the pattern
                if (r_rq != r_pq) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end else if ((LW+1)'(r_j) + 1'b1 == (LW+1)'(r_len)) begin
                    n_found = 1'b1;
                    n_state = r_last ? S_EMIT : S_IDLE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_vp    = next_slot(r_vp, r_len);
                    n_state = S_CMP_RD;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    if (r_ovf) begin
                        n_out_found  = 1'b0;
                        n_out_status = ST_OVERFLOW;
                    end else if (r_cnt < r_len) begin
                        n_out_found  = 1'b0;
                        n_out_status = ST_SHORT;
                    end else begin
                        n_out_found  = r_found;
                        n_out_status = ST_OK;
                    end
                    n_len     = '0;
                    n_cnt     = '0;
                    n_rp      = '0;
                    n_ph      = '0;
                    n_wh      = '0;
                    n_tp      = HASH_W'(1);
                    n_found   = 1'b0;
                    n_ovf     = 1'b0;
                    n_closed  = 1'b0;
                    n_tp_pend = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_PHASH;
            r_len       <= '0;
            r_cnt       <= '0;
            r_rp        <= '0;
            r_ph        <= '0;
            r_wh        <= '0;
            r_tp        <= HASH_W'(1);
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_closed    <= 1'b0;
            r_tp_pend   <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_j         <= '0;
            r_vp        <= '0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_rp        <= n_rp;
            r_ph        <= n_ph;
            r_wh        <= n_wh;
            r_tp        <= n_tp;
            r_found     <= n_found;
            r_ovf       <= n_ovf;
            r_closed    <= n_closed;
            r_tp_pend   <= n_tp_pend;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_j         <= n_j;
            r_vp        <= n_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c          <= n_c;
        r_x          <= n_x;
        r_q          <= n_q;
        r_rem        <= n_rem;
        r_sub        <= n_sub;
        r_opa        <= n_opa;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (pstore_we) begin
            pstore[r_len[AW-1:0]] <= i_char_value;
        end
        if (r_state == S_CMP_RD) begin
            r_pq <= pstore[r_j];
        end
    end

    // read-first: the roll sees the byte being replaced
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring[r_rp] <= i_char_value;
        end
        if (ring_re) begin
            r_rq <= ring[ring_ra];
        end
    end

    `RHSS_ASSERT_NOW(a_hash_range, 1'b1,
        r_ph < HASH_MOD && r_wh < HASH_MOD && r_tp < HASH_MOD,
        "hash register out of modular range")
    `RHSS_ASSERT_NOW(a_window_bounds, 1'b1,
        r_cnt <= r_len && (r_len == '0 || (LW+1)'(r_rp) < (LW+1)'(r_len)),
        "window count or ring pointer past pattern length")
    `RHSS_ASSERT_NOW(a_overflow_full, r_ovf, r_len == LW'(MAX_PATTERN),
        "overflow flagged with room left in the pattern store")
    `RHSS_ASSERT_NOW(a_found_closed, r_found, r_closed,
        "match flagged before the pattern was closed")
    `RHSS_ASSERT_NEXT(a_emit_clears, r_state == S_EMIT && emit_go,
        o_valid && r_len == '0 && !r_found && !r_closed && !r_ovf,
        "result posted without clearing the search state")

endmodule

### tb/sv/rolling_hash_substring_search_tb.sv
// Testbench for the rolling hash substring search: directed and random searches, self-checked.
`timescale 1ns / 1ps

module rolling_hash_substring_search_tb;
    import rhss_pkg::*;

    localparam int              MAX_PAT    = 32;
    localparam longint unsigned HASH_PRIME = 64'd1000000007;
    localparam longint unsigned HASH_RADIX = 64'd100;
    localparam int              BYTE_GOAL  = 1150;
    localparam int              DRAIN_WAIT = 100;

    typedef enum logic {
        ACT_PATTERN = 1'b0,
        ACT_TEXT    = 1'b1
    } t_byte_kind;

    typedef struct {
        logic    found;
        t_status status;
    } t_search_report;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_action     = 1'b0;
    logic [7:0] i_char_value = 8'h00;
    logic       i_last       = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_found;
    logic [1:0] o_status;

    bit idle_on        = 1'b1;
    int holdoff_cycles = 0;
    int mismatches     = 0;
    int reports_seen   = 0;
    int bytes_used     = 0;

    t_search_report pending_reports [$];

    // search state mirrored from the block
    logic [7:0]  pat_mem [MAX_PAT];
    logic [7:0]  win_mem [MAX_PAT];
    int          pat_len;
    logic [29:0] pat_hash;
    logic [29:0] win_hash;
    logic [29:0] top_pow;
    int          txt_cnt;
    int          win_ptr;
    bit          hit_seen;
    bit          pat_overflow;
    bit          pat_done;

    rolling_hash_substring_search u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_char_value (i_char_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_found      (o_found),
        .o_status     (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [29:0] hash_push(input logic [29:0] h, input logic [7:0] c);
        longint unsigned acc;
        acc = h;
        acc = (acc * HASH_RADIX + c) % HASH_PRIME;
        return acc[29:0];
    endfunction

    function automatic void clear_search_state();
        pat_len      = 0;
        pat_hash     = '0;
        win_hash     = '0;
        top_pow      = 30'd1;
        txt_cnt      = 0;
        win_ptr      = 0;
        hit_seen     = 1'b0;
        pat_overflow = 1'b0;
        pat_done     = 1'b0;
    endfunction

    function automatic int ring_next(input int p);
        return (p + 1 >= pat_len) ? 0 : p + 1;
    endfunction

    function automatic bit window_equals_pattern();
        int p;
        p = win_ptr;
        for (int j = 0; j < pat_len; j++) begin
            if (win_mem[p] != pat_mem[j])
                return 1'b0;
            p = ring_next(p);
        end
        return 1'b1;
    endfunction

    function automatic void roll_text_byte(input logic [7:0] ch);
        longint unsigned drop;
        longint unsigned acc;
        if (pat_overflow)
            return;
        if (pat_len == 0) begin
            hit_seen = 1'b1;
            return;
        end
        if (txt_cnt >= pat_len) begin
            // remove the oldest byte times 100^(m-1)
            drop = win_mem[win_ptr];
            drop = (drop * top_pow) % HASH_PRIME;
            acc = win_hash;
            acc = (acc + HASH_PRIME - drop) % HASH_PRIME;
            win_hash = acc[29:0];
        end else begin
            txt_cnt++;
        end
        win_hash = hash_push(win_hash, ch);
        win_mem[win_ptr] = ch;
        win_ptr = ring_next(win_ptr);
        if (txt_cnt >= pat_len && win_hash == pat_hash && window_equals_pattern())
            hit_seen = 1'b1;
    endfunction

    // Returns 0 for a beat the block merely ignores.
    function automatic bit predict_search_byte(input t_byte_kind kind, input logic [7:0] ch,
                                               input logic lst);
        longint unsigned acc;
        t_search_report  rpt;
        bit              used;
        if (kind == ACT_PATTERN) begin
            if (pat_done)
                return 1'b0;
            if (pat_len >= MAX_PAT) begin
                pat_overflow = 1'b1;
            end else begin
                pat_mem[pat_len] = ch;
                pat_hash = hash_push(pat_hash, ch);
                if (pat_len > 0) begin
                    acc = top_pow;
                    acc = (acc * HASH_RADIX) % HASH_PRIME;
                    top_pow = acc[29:0];
                end
                pat_len++;
            end
            if (lst)
                pat_done = 1'b1;
            return 1'b1;
        end
        used = !pat_overflow || lst;
        pat_done = 1'b1;
        roll_text_byte(ch);
        if (lst) begin
            if (pat_overflow) begin
                rpt.found  = 1'b0;
                rpt.status = ST_OVERFLOW;
            end else if (txt_cnt < pat_len) begin
                rpt.found  = 1'b0;
                rpt.status = ST_SHORT;
            end else begin
                rpt.found  = hit_seen;
                rpt.status = ST_OK;
            end
            pending_reports = {pending_reports, rpt};
            clear_search_state();
        end
        return used;
    endfunction

    task automatic send_search_byte(input t_byte_kind kind, input logic [7:0] ch,
                                    input logic lst);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= kind;
        i_char_value <= ch;
        i_last       <= lst;
        do @(posedge i_clk); while (o_stall);
        bytes_used += predict_search_byte(kind, ch, lst);
    endtask

    // Receiver side: random stall, or a long hold when one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (holdoff_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (holdoff_cycles) @(negedge i_clk);
                holdoff_cycles = 0;
            end else begin
                i_stall <= idle_on && ($urandom_range(0, 99) < 20);
            end
        end
    end

    always @(posedge i_clk) begin
        t_search_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected report, expected none, actual found=%0d status=%0d",
                         $time, o_found, o_status);
            end else begin
                want = pending_reports.pop_front();
                if (o_found !== want.found) begin
                    mismatches++;
                    $display("%0t: found mismatch, expected %0d, actual %0d",
                             $time, want.found, o_found);
                end
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    task automatic test_empty_pattern();
        send_search_byte(ACT_TEXT, 8'h00, 1'b0);
        send_search_byte(ACT_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_boundary_bytes();
        send_search_byte(ACT_PATTERN, 8'h00, 1'b0);
        send_search_byte(ACT_PATTERN, 8'hFF, 1'b0);
        send_search_byte(ACT_PATTERN, 8'h80, 1'b1);
        send_search_byte(ACT_TEXT, 8'h7F, 1'b0);
        send_search_byte(ACT_TEXT, 8'h00, 1'b0);
        send_search_byte(ACT_TEXT, 8'hFF, 1'b0);
        send_search_byte(ACT_TEXT, 8'h80, 1'b0);
        send_search_byte(ACT_TEXT, 8'h01, 1'b1);
        send_search_byte(ACT_PATTERN, 8'hFF, 1'b1);
        send_search_byte(ACT_TEXT, 8'h00, 1'b1);
    endtask

    task automatic test_short_text();
        send_search_byte(ACT_PATTERN, 8'h11, 1'b0);
        send_search_byte(ACT_PATTERN, 8'h22, 1'b0);
        send_search_byte(ACT_PATTERN, 8'h33, 1'b0);
        send_search_byte(ACT_PATTERN, 8'h44, 1'b1);
        send_search_byte(ACT_TEXT, 8'h11, 1'b0);
        send_search_byte(ACT_TEXT, 8'h22, 1'b1);
    endtask

    // Text closes an unterminated pattern; a late pattern byte is dropped.
    task automatic test_open_pattern();
        send_search_byte(ACT_PATTERN, 8'h5A, 1'b0);
        send_search_byte(ACT_PATTERN, 8'hA5, 1'b0);
        send_search_byte(ACT_TEXT, 8'h5A, 1'b0);
        send_search_byte(ACT_PATTERN, 8'h3C, 1'b0);
        send_search_byte(ACT_TEXT, 8'hA5, 1'b1);
        send_search_byte(ACT_PATTERN, 8'h3C, 1'b1);
        send_search_byte(ACT_PATTERN, 8'hC3, 1'b1);
        send_search_byte(ACT_TEXT, 8'h3C, 1'b1);
    endtask

    task automatic test_pattern_overflow();
        for (int i = 0; i <= MAX_PAT; i++)
            send_search_byte(ACT_PATTERN, 8'($urandom_range(0, 255)), i == MAX_PAT);
        send_search_byte(ACT_TEXT, 8'h00, 1'b0);
        send_search_byte(ACT_TEXT, 8'hFF, 1'b1);
    endtask

    // Hold the result side for a long stretch while searches keep coming.
    task automatic test_result_holdoff();
        holdoff_cycles = 300;
        for (int k = 0; k < 4; k++) begin
            send_search_byte(ACT_PATTERN, 8'h41, 1'b1);
            send_search_byte(ACT_TEXT, (k % 2 == 0) ? 8'h41 : 8'h42, 1'b0);
            send_search_byte(ACT_TEXT, 8'h42, 1'b1);
        end
    endtask

    function automatic logic [7:0] pick_symbol(input logic [7:0] base, input int nsym);
        if (nsym == 0)
            return 8'($urandom_range(0, 255));
        return base ^ 8'($urandom_range(0, nsym - 1));
    endfunction

    task automatic test_random_searches();
        int         plen;
        int         tlen;
        int         nsym;
        int         pick;
        int         spot;
        int         quiet_until;
        bit         close_pat;
        logic [7:0] base;
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        quiet_until = bytes_used + 250;
        idle_on = 1'b0;
        while (bytes_used < BYTE_GOAL) begin
            if (bytes_used >= quiet_until)
                idle_on = 1'b1;
            // a small alphabet makes hash hits and true matches frequent
            nsym = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4) : 0;
            base = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 3)
                plen = 0;
            else if (pick < 85)
                plen = $urandom_range(1, 6);
            else if (pick < 95)
                plen = $urandom_range(7, MAX_PAT);
            else
                plen = $urandom_range(MAX_PAT + 1, MAX_PAT + 4);
            pat.delete();
            for (int i = 0; i < plen; i++)
                pat = {pat, pick_symbol(base, nsym)};
            close_pat = (plen > MAX_PAT) || ($urandom_range(0, 99) < 85);
            for (int i = 0; i < plen; i++)
                send_search_byte(ACT_PATTERN, pat[i], close_pat && (i == plen - 1));
            if ($urandom_range(0, 99) < 8)
                send_search_byte(ACT_PATTERN, pick_symbol(base, nsym),
                                 1'($urandom_range(0, 1)));

            if (plen > 1 && plen <= MAX_PAT && $urandom_range(0, 99) < 10)
                tlen = $urandom_range(1, plen - 1);
            else
                tlen = plen + $urandom_range(0, (plen > 8) ? 12 : 20);
            if (tlen < 1)
                tlen = 1;
            txt.delete();
            for (int i = 0; i < tlen; i++)
                txt = {txt, pick_symbol(base, nsym)};
            if (plen > 0 && plen <= MAX_PAT && plen <= tlen && $urandom_range(0, 1) == 1) begin
                spot = $urandom_range(0, tlen - plen);
                for (int j = 0; j < plen; j++)
                    txt[spot + j] = pat[j];
            end
            for (int i = 0; i < tlen; i++) begin
                if ($urandom_range(0, 99) < 3)
                    send_search_byte(ACT_PATTERN, pick_symbol(base, nsym), 1'b0);
                send_search_byte(ACT_TEXT, txt[i], i == tlen - 1);
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        clear_search_state();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_boundary_bytes();
        test_short_text();
        test_open_pattern();
        test_pattern_overflow();
        test_result_holdoff();
        test_random_searches();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d search bytes and %0d reports: empty, short, overflowing,",
                 bytes_used, reports_seen);
        $display("unterminated and long patterns, with random gaps and a long result hold.");
        if (mismatches == 0)
            $display("[rolling_hash_substring_search] OK");
        else
            $display("[rolling_hash_substring_search] ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("[rolling_hash_substring_search] ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/rhss_pkg.sv
design/rolling_hash_substring_search.sv
tb/sv/rolling_hash_substring_search_tb.sv
